// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int OCC_W            = 5;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic [7:0]  prio;
      logic [3:0]  status;
      logic [15:0] amount;
      logic [7:0]  system;
      logic [7:0]  resource;
   } entry_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  prio;
      logic [3:0]  status_code;
      logic [15:0] amount_value;
      logic [7:0]  system_tag;
      logic [7:0]  resource_tag;
   } req_type;

   typedef struct packed {
      logic             found;
      logic             overflow;
      logic [7:0]       out_prio;
      logic [3:0]       out_status;
      logic [15:0]      out_amount;
      logic [7:0]       out_system;
      logic [7:0]       out_resource;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/stable_priority_event_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stable priority event queue. Holds up to CAPACITY events sorted by priority,
// highest first; equal priorities leave in arrival order. A push beat inserts
// the event behind every stored event of greater or equal priority, a pop beat
// removes and returns the head. Storage is a row of CAPACITY cells: on a push
// every cell compares its priority with the new one in the same cycle and
// either holds, loads the new event, or takes its left neighbor; on a pop every
// cell takes its right neighbor. One beat is taken per cycle while req_stall is
// low, and its result appears in the response register on the next cycle.
// Throughput is set by the single cell compare and shift per cycle; a new request
// enters as the previous result is taken, so req_stall rises only when
// a result is held and rsp_stall is high. A push on a full queue is dropped and
// flagged with overflow; a pop on an empty queue returns found low and zeros.
// No clearing pass follows reset: the queue is usable on the first cycle.
module stable_priority_event_queue_core #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output spq_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   spq_pkg::rsp_type      rsp_ff;
   spq_pkg::rsp_type      rsp_in;

   spq_pkg::entry_type    cell_q [CAPACITY];
   logic [CAPACITY-1:0]   cell_ge;
   spq_pkg::entry_type    new_entry;
   spq_pkg::cell_ctl_type ctl;

   logic accept;
   logic full;
   logic empty;
   logic is_pop;

   // hold a finished result only while the consumer stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign is_pop = (req_data.func == spq_pkg::FUNC_POP);

   assign ctl.push = accept && !is_pop && !full;
   assign ctl.pop  = accept && is_pop && !empty;

   assign new_entry.prio     = req_data.prio;
   assign new_entry.status   = req_data.status_code;
   assign new_entry.amount   = req_data.amount_value;
   assign new_entry.system   = req_data.system_tag;
   assign new_entry.resource = req_data.resource_tag;

   // row of cells; cell zero is the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_ge;
      logic               valid;

      assign valid = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_ge    = 1'b1;
      end else begin : g_body
         assign left_entry = cell_q[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // tail drops out of the valid range on a pop, so its contents do not matter
         assign right_entry = cell_q[i];
      end else begin : g_inner
         assign right_entry = cell_q[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .valid       (valid),
         .entry_q     (cell_q[i]),
         .ge          (cell_ge[i])
      );
   end

   // count and response for the beat taken this cycle
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_in           = '0;
      rsp_in.occupancy = spq_pkg::OCC_W'(count_in);
      if (is_pop) begin
         if (!empty) begin
            rsp_in.found        = 1'b1;
            rsp_in.out_prio     = cell_q[0].prio;
            rsp_in.out_status   = cell_q[0].status;
            rsp_in.out_amount   = cell_q[0].amount;
            rsp_in.out_system   = cell_q[0].system;
            rsp_in.out_resource = cell_q[0].resource;
         end
      end else begin
         rsp_in.overflow = full;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register: load on every accepted beat, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic                 clock,
   input  wire spq_pkg::cell_ctl_type ctl,
   input  wire spq_pkg::entry_type    new_entry,
   input  wire spq_pkg::entry_type    left_entry,
   input  wire logic                 left_ge,
   input  wire spq_pkg::entry_type    right_entry,
   input  wire logic                 valid,
   output spq_pkg::entry_type         entry_q,
   output logic                      ge
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // keep on ties so equal priorities leave in arrival order
   assign ge      = valid && (entry_ff.prio >= new_entry.prio);
   assign entry_q = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (!ge) begin
            entry_in = left_ge ? new_entry : left_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
